[hdl/vnu_pkg.sv]
// ---------------------------------------------------------------------------
// vnu_pkg: shared constants, types and step functions
// Widths and step arithmetic for the four-lane vector normalisation unit.
// ---------------------------------------------------------------------------
package vnu_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int INT_BITS    = 8;
  localparam int IN_W        = INT_BITS + FRAC_BITS;
  localparam int LEN_W       = IN_W + 1;
  localparam int UNIT_W      = FRAC_BITS + 2;
  localparam int SQ_W        = 2 * IN_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int SQRT_STAGES = SUM_W / 2;
  localparam int SQRT_REM_W  = LEN_W + 2;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int DIV_STAGES  = QUO_W;
  localparam int LANES       = 4;
  localparam int PRE_STAGES  = 3;
  localparam int PIPE_DEPTH  = PRE_STAGES + SQRT_STAGES + DIV_STAGES;

  localparam logic [QUO_W-1:0] ONE_FIX = QUO_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [SQRT_REM_W-1:0] rem;
    logic [LEN_W-1:0]      root;
  } sqrt_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic             qbit;
  } div_t;

  function automatic sqrt_t sqrt_step(input logic [SQRT_REM_W-1:0] rem,
                                      input logic [LEN_W-1:0] root,
                                      input logic [1:0] pair);
    logic [SQRT_REM_W+1:0] t;
    logic [SQRT_REM_W+1:0] trial;
    sqrt_t                 r;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      r.rem  = SQRT_REM_W'(t - trial);
      r.root = {root[LEN_W-2:0], 1'b1};
    end else begin
      r.rem  = SQRT_REM_W'(t);
      r.root = {root[LEN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_step(input logic [LEN_W-1:0] rem,
                                    input logic in_bit,
                                    input logic [LEN_W-1:0] den);
    logic [LEN_W:0] t;
    div_t           r;
    t = {rem, in_bit};
    if (t >= {1'b0, den}) begin
      r.rem  = LEN_W'(t - {1'b0, den});
      r.qbit = 1'b1;
    end else begin
      r.rem  = t[LEN_W-1:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/vnu_sqrt.sv]
// ---------------------------------------------------------------------------
// vnu_sqrt: pipelined floor square root
// Digit-by-digit square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module vnu_sqrt
  import vnu_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic [LEN_W-1:0] root_o
);

  logic [SQRT_REM_W-1:0] rem_q  [SQRT_STAGES];
  logic [LEN_W-1:0]      root_q [SQRT_STAGES];
  logic [SUM_W-1:0]      rad_q  [SQRT_STAGES];
  sqrt_t                 step_d [SQRT_STAGES];

  assign step_d[0] = sqrt_step('0, '0, sum_i[SUM_W-1 -: 2]);

  for (genvar k = 1; k < SQRT_STAGES; k++) begin : g_step
    assign step_d[k] = sqrt_step(rem_q[k-1], root_q[k-1], rad_q[k-1][SUM_W-1 -: 2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= step_d[0].rem;
      root_q[0] <= step_d[0].root;
      rad_q[0]  <= sum_i << 2;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        rem_q[k]  <= step_d[k].rem;
        root_q[k] <= step_d[k].root;
        rad_q[k]  <= rad_q[k-1] << 2;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

[hdl/vnu_div_lane.sv]
// ---------------------------------------------------------------------------
// vnu_div_lane: one lane of the normalising divider
// Pipelined restoring division of a component by the length, clamped to one (zero for zero length), then sign.
// ---------------------------------------------------------------------------
module vnu_div_lane
  import vnu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [IN_W-1:0]          mag_i,
  input  logic                     neg_i,
  input  logic [LEN_W-1:0]         len_i,
  output logic signed [UNIT_W-1:0] unit_o
);

  logic [LEN_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [LEN_W-1:0] len_q [DIV_STAGES];
  logic             neg_q [DIV_STAGES];
  div_t             step_d [DIV_STAGES];
  logic [QUO_W-1:0] quo;

  assign step_d[0] = div_step(LEN_W'(mag_i[IN_W-1:1]), mag_i[0], len_i);

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    assign step_d[k] = div_step(rem_q[k-1], 1'b0, len_q[k-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= step_d[0].rem;
      quo_q[0] <= QUO_W'(step_d[0].qbit);
      len_q[0] <= len_i;
      neg_q[0] <= neg_i;
      for (int k = 1; k < DIV_STAGES; k++) begin
        rem_q[k] <= step_d[k].rem;
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], step_d[k].qbit};
        len_q[k] <= len_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  always_comb begin
    if (len_q[DIV_STAGES-1] == '0) begin
      quo = '0;
    end else if (quo_q[DIV_STAGES-1] > ONE_FIX) begin
      quo = ONE_FIX;
    end else begin
      quo = quo_q[DIV_STAGES-1];
    end
    if (neg_q[DIV_STAGES-1]) begin
      unit_o = UNIT_W'(-{1'b0, quo});
    end else begin
      unit_o = UNIT_W'({1'b0, quo});
    end
  end

endmodule

[hdl/vector4_normalize_unit.sv]
// ---------------------------------------------------------------------------
// vector4_normalize_unit: four-component fixed-point vector normaliser
// Fully pipelined; one item per cycle sustained while the output does not stall.
// The depth is set by the 25-stage square root and the 17-stage dividers.
// The whole pipeline advances together and holds while the output stalls.
// Reset clears the valid flags only, asynchronously; data is not reset.
// ---------------------------------------------------------------------------
module vector4_normalize_unit
  import vnu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // comp_x[23:0], comp_y[47:24], comp_z[71:48], comp_w[95:72]
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // unit_x[17:0], unit_y[35:18], unit_z[53:36], unit_w[71:54], length[96:72]
  output logic [103:0] m_axis_tdata_o,
  // zero_vector[0]
  output logic         m_axis_tuser_o
);

  logic                     en;
  logic [PIPE_DEPTH-1:0]    vld_q;
  logic                     out_vld_q;
  logic [IN_W-1:0]          in_comp [LANES];
  logic [IN_W-1:0]          mag0_q  [LANES];
  logic                     neg0_q  [LANES];
  logic [IN_W-1:0]          mag1_q  [LANES];
  logic                     neg1_q  [LANES];
  logic [SQ_W-1:0]          sq1_q   [LANES];
  logic [IN_W-1:0]          mag2_q  [LANES];
  logic                     neg2_q  [LANES];
  logic [SUM_W-1:0]         sum2_q;
  logic [IN_W-1:0]          mag_dl_q [SQRT_STAGES][LANES];
  logic                     neg_dl_q [SQRT_STAGES][LANES];
  logic [LEN_W-1:0]         root;
  logic [LEN_W-1:0]         len_dl_q [DIV_STAGES];
  logic signed [UNIT_W-1:0] unit_d  [LANES];
  logic signed [UNIT_W-1:0] unit_q  [LANES];
  logic [LEN_W-1:0]         len_q;
  logic                     zero_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar i = 0; i < LANES; i++) begin : g_in
    assign in_comp[i] = s_axis_tdata_i[i*IN_W +: IN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        neg0_q[i] <= in_comp[i][IN_W-1];
        mag0_q[i] <= in_comp[i][IN_W-1] ? IN_W'(-in_comp[i]) : in_comp[i];
        mag1_q[i] <= mag0_q[i];
        neg1_q[i] <= neg0_q[i];
        sq1_q[i]  <= mag0_q[i] * mag0_q[i];
        mag2_q[i] <= mag1_q[i];
        neg2_q[i] <= neg1_q[i];
        mag_dl_q[0][i] <= mag2_q[i];
        neg_dl_q[0][i] <= neg2_q[i];
        for (int k = 1; k < SQRT_STAGES; k++) begin
          mag_dl_q[k][i] <= mag_dl_q[k-1][i];
          neg_dl_q[k][i] <= neg_dl_q[k-1][i];
        end
        unit_q[i] <= unit_d[i];
      end
      sum2_q <= SUM_W'(sq1_q[0]) + SUM_W'(sq1_q[1]) + SUM_W'(sq1_q[2]) + SUM_W'(sq1_q[3]);
      len_dl_q[0] <= root;
      for (int k = 1; k < DIV_STAGES; k++) begin
        len_dl_q[k] <= len_dl_q[k-1];
      end
      len_q  <= len_dl_q[DIV_STAGES-1];
      zero_q <= (len_dl_q[DIV_STAGES-1] == '0);
    end
  end

  vnu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum2_q),
    .root_o (root)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vnu_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (mag_dl_q[SQRT_STAGES-1][i]),
      .neg_i  (neg_dl_q[SQRT_STAGES-1][i]),
      .len_i  (root),
      .unit_o (unit_d[i])
    );
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, len_q, unit_q[3], unit_q[2], unit_q[1], unit_q[0]};
  assign m_axis_tuser_o  = zero_q;

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: self-checking bench for vector4_normalize_unit
// Drives random and directed vectors through the stream input with random
// gaps and output stalls, predicts magnitude and unit vector per item, and
// compares every result field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import vnu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IN_W-1:0] w;
    logic [IN_W-1:0] z;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [UNIT_W-1:0] uw;
    logic [UNIT_W-1:0] uz;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] ux;
    logic              zero;
  } norm_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  vec_t  pending_vecs[$];
  norm_t expected_norms[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    send_gap = 0;
  int    stall_left = 0;
  bit    stim_done = 1'b0;
  bit    hold_input = 1'b0;

  vector4_normalize_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic norm_t normalize(vec_t v);
    logic [IN_W-1:0]  mag[4];
    logic             neg[4];
    logic [IN_W-1:0]  raw[4];
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] root;
    logic [LEN_W-1:0] cand;
    logic [63:0]      q;
    logic [UNIT_W-1:0] u[4];
    norm_t            n;
    raw[0] = v.x; raw[1] = v.y; raw[2] = v.z; raw[3] = v.w;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = raw[i][IN_W-1];
      mag[i] = neg[i] ? -raw[i] : raw[i];
      sum += SUM_W'(mag[i]) * SUM_W'(mag[i]);
    end
    root = '0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      cand = root | (LEN_W'(1) << b);
      if (SUM_W'(cand) * SUM_W'(cand) <= sum) root = cand;
    end
    for (int i = 0; i < 4; i++) begin
      q = '0;
      if (root != 0) begin
        q = (64'(mag[i]) << FRAC_BITS) / 64'(root);
        if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
      end
      if (neg[i]) q = -q;
      u[i] = q[UNIT_W-1:0];
    end
    n.ux = u[0]; n.uy = u[1]; n.uz = u[2]; n.uw = u[3];
    n.len = root;
    n.zero = (root == 0);
    return n;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("Mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got,
             want);
    error_count++;
  endtask

  function automatic logic [IN_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return {1'b1, {(IN_W-1){1'b0}}};
    if (r == 2) return {1'b0, {(IN_W-1){1'b1}}};
    if (r == 3) return IN_W'($urandom_range(0, 600)) - IN_W'(300);
    return IN_W'($urandom);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_norms.push_back(normalize(vec_t'(s_axis_tdata_i)));
        void'(pending_vecs.pop_front());
        send_gap = pick_gap();
      end else if (!s_axis_tvalid_i && send_gap > 0) begin
        send_gap--;
      end
      if (pending_vecs.size() > 0 && send_gap == 0 && !hold_input) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_vecs[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    norm_t want;
    norm_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[96:0], m_axis_tuser_o};
        if (expected_norms.size() == 0) begin
          $display("Unexpected item at cycle %0d", cycle_count);
          error_count++;
        end else begin
          want = expected_norms.pop_front();
          if (got.ux !== want.ux) report_mismatch("unit_x", 64'(got.ux), 64'(want.ux));
          if (got.uy !== want.uy) report_mismatch("unit_y", 64'(got.uy), 64'(want.uy));
          if (got.uz !== want.uz) report_mismatch("unit_z", 64'(got.uz), 64'(want.uz));
          if (got.uw !== want.uw) report_mismatch("unit_w", 64'(got.uw), 64'(want.uw));
          if (got.len !== want.len)
            report_mismatch("length", 64'(got.len), 64'(want.len));
          if (got.zero !== want.zero)
            report_mismatch("zero_vector", 64'(got.zero), 64'(want.zero));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (cycle_count % 3000 < 1000) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        m_axis_tready_i <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    vec_t v;
    logic [IN_W-1:0] mx;
    logic [IN_W-1:0] mn;
    mx = {1'b0, {(IN_W-1){1'b1}}};
    mn = {1'b1, {(IN_W-1){1'b0}}};
    pending_vecs.push_back('{w: '0, z: '0, y: '0, x: '0});
    pending_vecs.push_back('{w: mx, z: mx, y: mx, x: mx});
    pending_vecs.push_back('{w: mn, z: mn, y: mn, x: mn});
    pending_vecs.push_back('{w: '0, z: '0, y: '0, x: mn});
    pending_vecs.push_back('{w: '0, z: '0, y: mx, x: '0});
    pending_vecs.push_back('{w: '0, z: mn, y: '0, x: '0});
    pending_vecs.push_back('{w: mx, z: '0, y: '0, x: '0});
    pending_vecs.push_back('{w: '0, z: '0, y: '0, x: IN_W'(1)});
    pending_vecs.push_back('{w: '1, z: '0, y: '0, x: '0});
    pending_vecs.push_back('{w: '1, z: IN_W'(1), y: '1, x: IN_W'(1)});
    pending_vecs.push_back('{w: mn, z: mx, y: mn, x: mx});
    pending_vecs.push_back('{w: IN_W'(1), z: mx, y: '0, x: '0});
    pending_vecs.push_back('{w: '0, z: '0, y: IN_W'(3), x: IN_W'(4)});
    pending_vecs.push_back('{w: '0, z: '0, y: -IN_W'(3 << 16), x: IN_W'(4 << 16)});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 1950; i++) begin
      if (i == 900) begin
        wait (pending_vecs.size() == 0);
        hold_input = 1'b1;
        wait (expected_norms.size() == 0);
        hold_input = 1'b0;
      end
      v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
      pending_vecs.push_back(v);
    end
    wait (pending_vecs.size() == 0);
    wait (expected_norms.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
